[hdl/deq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: command and status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   // default number of ring slots
   localparam int DEQ_DEPTH = 16;

   // field widths
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // command codes, anything else behaves as a query
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } deq_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the request word
      logic exec;   // carry out the captured command
   } deq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // result register can take a new word this cycle
   } deq_status_type;

endpackage

`default_nettype wire

[hdl/double_ended_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words kept in a ring buffer.
// Push and pop at either end, query for empty; one result word per request.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cmd, req_value
//   rsp      out        rsp_valid/rsp_stall  rsp_read_value, rsp_status,
//                                            rsp_now_empty
//
// A request word is handled in two steps: capture, then the single slot
// memory access and pointer update; the next word is taken after both.
// The result word sits in an output register; a new request is taken while
// it waits, and its execute step holds until that register is free.
// Synchronous reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
)(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic        [CMD_W-1:0]    req_cmd,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic signed [VALUE_W-1:0]  rsp_read_value,
   output      logic        [STATUS_W-1:0] rsp_status,
   output      logic                       rsp_now_empty
);

   deq_cmd_type    dp_cmd;
   deq_status_type dp_status;

   // sequencing
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // ring buffer and result register
   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty)
   );

endmodule

`default_nettype wire

[hdl/deq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller for the double-ended queue: takes a request word, then issues
// the execute step once the result register is free.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_stall,
   output      deq_cmd_type    dp_cmd,
   input  wire deq_status_type dp_status
);

   deq_state_type state_ff;
   deq_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (dp_status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = 1'b1;
      dp_cmd.load = 1'b0;
      dp_cmd.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            dp_cmd.load = req_valid;
         end
         ST_EXEC: begin
            dp_cmd.exec = dp_status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/deq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_datapath
// Ring buffer datapath: request register, head pointer and fill count,
// slot memory and the result register.
// ----------------------------------------------------------------------------
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
)(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire deq_cmd_type                dp_cmd,
   output      deq_status_type             dp_status,
   input  wire logic        [CMD_W-1:0]    req_cmd,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic signed [VALUE_W-1:0]  rsp_read_value,
   output      logic        [STATUS_W-1:0] rsp_status,
   output      logic                       rsp_now_empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(DEPTH - 1);

   // captured request word
   logic        [CMD_W-1:0]    cmd_ff;
   logic signed [VALUE_W-1:0]  value_ff;

   // ring pointers
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // result register
   logic                       rsp_valid_ff;
   logic signed [VALUE_W-1:0]  rsp_value_ff;
   logic        [STATUS_W-1:0] rsp_status_ff;
   logic                       rsp_empty_ff;
   logic        [STATUS_W-1:0] status_in;

   // slot memory
   logic signed [VALUE_W-1:0] slots [DEPTH];
   logic                      mem_we;
   logic                      mem_re;
   logic [IDX_W-1:0]          mem_addr;

   // address arithmetic
   logic             is_empty;
   logic             is_full;
   logic [IDX_W-1:0] head_dec;
   logic [IDX_W-1:0] head_inc;
   logic [SUM_W-1:0] rear_sum;
   logic [SUM_W-1:0] last_sum;
   logic [IDX_W-1:0] rear_pos;
   logic [IDX_W-1:0] last_pos;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= DEPTH_C);

   assign head_dec = (head_ff == '0) ? LAST_INDEX : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_INDEX) ? '0 : head_ff + 1'b1;

   // rear free slot and last occupied slot, wrapped once
   assign rear_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign last_sum = rear_sum - 1'b1;
   assign rear_pos = (rear_sum >= DEPTH_S) ? IDX_W'(rear_sum - DEPTH_S) : IDX_W'(rear_sum);
   assign last_pos = (last_sum >= DEPTH_S) ? IDX_W'(last_sum - DEPTH_S) : IDX_W'(last_sum);

   // request capture
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
      end
   end

   // command decode and next pointers
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = head_ff;
      case (cmd_ff)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
               mem_we   = dp_cmd.exec;
               mem_addr = head_dec;
            end
         end
         CMD_PUSH_REAR: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               mem_we   = dp_cmd.exec;
               mem_addr = rear_pos;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               mem_re   = 1'b1;
               mem_addr = head_ff;
            end
         end
         CMD_POP_REAR: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               mem_re   = 1'b1;
               mem_addr = last_pos;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (dp_cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // slot write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots[mem_addr] <= value_ff;
      end
   end

   // slot read straight into the result word
   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         rsp_value_ff  <= mem_re ? slots[mem_addr] : '0;
         rsp_status_ff <= status_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_now_empty  = rsp_empty_ff;

endmodule

`default_nettype wire

[tb/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer deque. A driver sends command words
// from a queue filled up front: directed corner cases first, then bursts of
// random pushes and pops. The bursts lean towards filling or draining, so the
// ring reaches full and empty many times. A local copy of the ring predicts
// each result word, and a monitor compares every field as the results come
// out. Both sides idle at random. Once, the receiver holds off for a long
// stretch so that back-pressure reaches the request side.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int IDX_W     = $clog2(DEQ_DEPTH);
   localparam int LIMIT     = 200000;
   localparam int HOLD_AT   = 60;
   localparam int HOLD_LEN  = 120;
   localparam int DRAIN_CYC = 20;

   // reserved command codes, the block treats them as a query
   localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

   typedef struct {
      logic        [CMD_W-1:0]   cmd;
      logic signed [VALUE_W-1:0] value;
      int                        gap_after;
   } cmd_word_type;

   typedef struct {
      logic signed [VALUE_W-1:0] read_value;
      logic        [STATUS_W-1:0] status;
      logic                       now_empty;
   } deque_outcome_type;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic        [CMD_W-1:0]    req_cmd   = CMD_QUERY;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_read_value;
   logic        [STATUS_W-1:0] rsp_status;
   logic                       rsp_now_empty;

   cmd_word_type      cmd_words[$];
   deque_outcome_type deque_outcomes[$];

   // local copy of the ring
   logic signed [VALUE_W-1:0] ring_slots [DEQ_DEPTH];
   logic        [IDX_W-1:0]   ring_head = '0;
   logic        [IDX_W:0]     ring_fill = '0;

   int errors       = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   int calm_left    = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   double_ended_queue i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one command to the local ring and give the result word it causes
   function automatic deque_outcome_type apply_deque_cmd(
      input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] value);
      deque_outcome_type res;
      logic [IDX_W-1:0]  pos;
      res.read_value = '0;
      res.status     = STATUS_OK;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (ring_fill == DEQ_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  ring_head = ring_head - 1'b1;
                  pos       = ring_head;
               end else begin
                  pos = ring_head + ring_fill[IDX_W-1:0];
               end
               ring_slots[pos] = value;
               ring_fill       = ring_fill + 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (ring_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               if (cmd == CMD_POP_FRONT) begin
                  res.read_value = ring_slots[ring_head];
                  ring_head      = ring_head + 1'b1;
               end else begin
                  pos            = ring_head + ring_fill[IDX_W-1:0] - 1'b1;
                  res.read_value = ring_slots[pos];
               end
               ring_fill = ring_fill - 1'b1;
            end
         end
         default: ;
      endcase
      res.now_empty = (ring_fill == 0);
      return res;
   endfunction

   // idle length: mostly none, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // push values: extremes, small numbers and full random
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_word(input logic [CMD_W-1:0] cmd,
                           input logic signed [VALUE_W-1:0] value, input int gap);
      cmd_word_type w;
      w.cmd       = cmd;
      w.value     = value;
      w.gap_after = gap;
      cmd_words.push_back(w);
   endtask

   // stimulus and end of run
   initial begin
      int   burst_len;
      int   push_pct;
      int   r;
      bit   calm;
      logic [CMD_W-1:0] cmd;

      // empty queue corner cases
      add_word(CMD_POP_FRONT, 32'sh1234_5678, pick_gap());
      add_word(CMD_POP_REAR, -1, pick_gap());
      add_word(CMD_RSVD_5, 32'sh7FFF_FFFF, pick_gap());
      add_word(CMD_PUSH_FRONT, 32'sh8000_0000, pick_gap());
      add_word(CMD_PUSH_REAR, 32'sh7FFF_FFFF, pick_gap());
      add_word(CMD_RSVD_6, -1, pick_gap());
      add_word(CMD_POP_REAR, 0, pick_gap());
      add_word(CMD_POP_FRONT, 0, pick_gap());
      add_word(CMD_RSVD_7, 32'sh8000_0000, pick_gap());
      // fill to the brim from both ends, then push on full
      for (int i = 0; i < DEQ_DEPTH; i++) begin
         add_word(i[0] ? CMD_PUSH_REAR : CMD_PUSH_FRONT,
                  (i < 2) ? (i[0] ? 32'sh0000_0000 : -1) : pick_value(), 0);
      end
      add_word(CMD_PUSH_FRONT, 32'sh5555_5555, pick_gap());
      add_word(CMD_PUSH_REAR, 32'shAAAA_AAAA, pick_gap());
      add_word(CMD_QUERY, 0, pick_gap());

      // random bursts leaning towards fill or drain
      while (cmd_words.size() < 400) begin
         burst_len = $urandom_range(8, 40);
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
         endcase
         calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < burst_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               cmd = CMD_QUERY;
            end else if (r < 8) begin
               case ($urandom_range(0, 2))
                  0:       cmd = CMD_RSVD_5;
                  1:       cmd = CMD_RSVD_6;
                  default: cmd = CMD_RSVD_7;
               endcase
            end else if ($urandom_range(0, 99) < push_pct) begin
               cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            end else begin
               cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
            end
            add_word(cmd, pick_value(), calm ? 0 : pick_gap());
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to be sent and every result to come back
      @(negedge clock);
      while (cmd_words.size() != 0 || req_valid || deque_outcomes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);

      if (errors == 0)
         $display("tb_double_ended_queue: done, clean");
      else
         $display("tb_double_ended_queue: done, errors");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      cmd_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            deque_outcomes.push_back(apply_deque_cmd(req_cmd, req_value));
         // the current word is gone or was never there
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_words.size() != 0) begin
               w         = cmd_words.pop_front();
               gap_left  = w.gap_after;
               req_valid <= 1'b1;
               req_cmd   <= w.cmd;
               req_value <= w.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      deque_outcome_type exp_word;
      logic              next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (deque_outcomes.size() == 0) begin
               $display("%0t unexpected result word: expected none, %s %0d %0d %0d",
                        $time, "got value, status, empty", rsp_read_value,
                        rsp_status, rsp_now_empty);
               errors++;
            end else begin
               exp_word = deque_outcomes.pop_front();
               if (rsp_read_value !== exp_word.read_value) begin
                  $display("%0t read_value mismatch: expected %0d, got %0d",
                           $time, exp_word.read_value, rsp_read_value);
                  errors++;
               end
               if (rsp_status !== exp_word.status) begin
                  $display("%0t status mismatch: expected %0d, got %0d",
                           $time, exp_word.status, rsp_status);
                  errors++;
               end
               if (rsp_now_empty !== exp_word.now_empty) begin
                  $display("%0t now_empty mismatch: expected %0d, got %0d",
                           $time, exp_word.now_empty, rsp_now_empty);
                  errors++;
               end
            end
         end

         // one long hold-off to back up the request side, else random stalls
         next_stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_LEN - 1;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(20, 60);
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               next_stall = 1'b1;
            end
         end
         rsp_stall <= next_stall;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("tb_double_ended_queue: done, errors");
         $finish;
      end
   end

endmodule
